// ----- rtl/core/fpq8_pkg.sv -----
// Shared types and constants for the fixed-point ALU.
package fpq8_pkg;

	// Default format: Q24.8 in a 32-bit word
	localparam int FRAC_BITS_DEF = 8;
	localparam int WORD_BITS_DEF = 32;

	// Entries in the queue between front and back
	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [3:0] {
		OP_ADD      = 4'd0,
		OP_SUB      = 4'd1,
		OP_MUL      = 4'd2,
		OP_DIV      = 4'd3,
		OP_GT       = 4'd4,
		OP_LT       = 4'd5,
		OP_GE       = 4'd6,
		OP_LE       = 4'd7,
		OP_EQ       = 4'd8,
		OP_NE       = 4'd9,
		OP_MIN      = 4'd10,
		OP_MAX      = 4'd11,
		OP_INC      = 4'd12,
		OP_DEC      = 4'd13,
		OP_TO_INT   = 4'd14,
		OP_FROM_INT = 4'd15
	} opcode_t;

	typedef enum logic [1:0] {
		ERR_OK   = 2'd0,
		ERR_OVF  = 2'd1,
		ERR_DIV0 = 2'd2
	} err_t;

	// Which back-end unit produces the result
	typedef enum logic [1:0] {
		KIND_SIMPLE = 2'd0,
		KIND_MUL    = 2'd1,
		KIND_DIV    = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t kind;
		logic  neg;   // result sign for mul and div
		logic  dz;    // divisor is zero
	} ctl_t;

endpackage

// ----- rtl/core/fpq8_front.sv -----
// Front end: classifies each request and prepares operand magnitudes.
module fpq8_front #(
	parameter int WORD_BITS = fpq8_pkg::WORD_BITS_DEF
) (
	input  logic [3:0]           opcode,
	input  logic [WORD_BITS-1:0] operand_a,
	input  logic [WORD_BITS-1:0] operand_b,
	output fpq8_pkg::ctl_t       ctl,
	output logic [WORD_BITS-1:0] mag_a,
	output logic [WORD_BITS-1:0] mag_b
);

	localparam int W = WORD_BITS;

	// Unit selection, sign of product or quotient, and zero divisor
	always_comb begin
		ctl.neg = operand_a[W-1] ^ operand_b[W-1];
		ctl.dz  = (operand_b == '0);
		unique case (fpq8_pkg::opcode_t'(opcode))
			fpq8_pkg::OP_MUL: ctl.kind = fpq8_pkg::KIND_MUL;
			fpq8_pkg::OP_DIV: ctl.kind = fpq8_pkg::KIND_DIV;
			default:          ctl.kind = fpq8_pkg::KIND_SIMPLE;
		endcase
	end

	// Magnitudes; the most negative word maps to 2^(W-1), which still fits
	assign mag_a = operand_a[W-1] ? (~operand_a + W'(1)) : operand_a;
	assign mag_b = operand_b[W-1] ? (~operand_b + W'(1)) : operand_b;

endmodule

// ----- rtl/core/fpq8_queue.sv -----
// Small request queue that decouples the front end from the back end.
module fpq8_queue #(
	parameter int DATA_W = 8,
	parameter int DEPTH  = fpq8_pkg::QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [DATA_W-1:0] push_data,
	output logic              full,
	input  logic              pop,
	output logic              empty,
	output logic [DATA_W-1:0] head
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  cnt_q;

	assign full  = (cnt_q == CNT_W'(DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rd_ptr_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ----- rtl/core/fpq8_back.sv -----
// Back end: simple ALU, pipelined multiplier and one-bit-per-stage divider.
module fpq8_back #(
	parameter int WORD_BITS = fpq8_pkg::WORD_BITS_DEF,
	parameter int FRAC_BITS = fpq8_pkg::FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 head_valid,
	output logic                 pop,
	input  fpq8_pkg::ctl_t       h_ctl,
	input  logic [3:0]           h_op,
	input  logic [WORD_BITS-1:0] h_a,
	input  logic [WORD_BITS-1:0] h_b,
	input  logic [WORD_BITS-1:0] h_ma,
	input  logic [WORD_BITS-1:0] h_mb,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output logic [WORD_BITS-1:0] result_value,
	output logic                 compare_true,
	output logic [1:0]           error_code
);

	localparam int W  = WORD_BITS;
	localparam int F  = FRAC_BITS;
	localparam int NQ = W + F;                          // quotient bits
	localparam int MW = (2 * W > NQ + 1) ? 2 * W : NQ + 1;
	localparam int H  = (W + 1) / 2;                    // multiplier half width
	localparam int PW = 4 * H;                          // full product width

	localparam logic [W-1:0] WMIN       = {1'b1, {(W-1){1'b0}}};
	localparam logic [W-1:0] WMAX       = ~WMIN;
	localparam logic [W-1:0] FI_NEG_LIM = WMIN >> F;
	localparam logic [W-1:0] FI_POS_LIM = WMAX >> F;
	localparam logic [W:0]   TI_HALF    = (W+1)'(1) << (F - 1);
	localparam logic [PW:0]  MUL_HALF   = (PW+1)'(1) << (F - 1);

	logic adv;
	logic out_vld_q;

	// Whole pipeline moves unless a finished result is held by the receiver
	assign adv = !out_vld_q || !rsp_stall;
	assign pop = adv && head_valid;

	// ---------------- simple ALU on the queue head ----------------
	logic [W-1:0]  addend;
	logic          do_sub;
	logic [W:0]    sum_w;
	logic          lt;
	logic [W:0]    ti_w;
	logic [W-1:0]  ti_m;
	logic [W-1:0]  s_res;
	logic          s_cmp;
	fpq8_pkg::err_t s_err;

	always_comb begin
		addend = h_b;
		do_sub = 1'b0;
		case (fpq8_pkg::opcode_t'(h_op)) inside
			fpq8_pkg::OP_INC: addend = W'(1);
			fpq8_pkg::OP_DEC: begin
				addend = W'(1);
				do_sub = 1'b1;
			end
			fpq8_pkg::OP_SUB: do_sub = 1'b1;
			default: ;
		endcase
	end

	assign sum_w = do_sub ? ({h_a[W-1], h_a} - {addend[W-1], addend})
	                      : ({h_a[W-1], h_a} + {addend[W-1], addend});
	assign lt    = $signed(h_a) < $signed(h_b);
	assign ti_w  = {1'b0, h_ma} + TI_HALF;
	assign ti_m  = W'(ti_w >> F);

	always_comb begin
		s_res = '0;
		s_cmp = 1'b0;
		s_err = fpq8_pkg::ERR_OK;
		unique case (fpq8_pkg::opcode_t'(h_op)) inside
			fpq8_pkg::OP_ADD, fpq8_pkg::OP_SUB, fpq8_pkg::OP_INC, fpq8_pkg::OP_DEC: begin
				if (sum_w[W] != sum_w[W-1]) begin
					s_res = h_a[W-1] ? WMIN : WMAX;
					s_err = fpq8_pkg::ERR_OVF;
				end else begin
					s_res = sum_w[W-1:0];
				end
			end
			fpq8_pkg::OP_GT:  s_cmp = !lt && (h_a != h_b);
			fpq8_pkg::OP_LT:  s_cmp = lt;
			fpq8_pkg::OP_GE:  s_cmp = !lt;
			fpq8_pkg::OP_LE:  s_cmp = lt || (h_a == h_b);
			fpq8_pkg::OP_EQ:  s_cmp = (h_a == h_b);
			fpq8_pkg::OP_NE:  s_cmp = (h_a != h_b);
			fpq8_pkg::OP_MIN: s_res = lt ? h_a : h_b;
			fpq8_pkg::OP_MAX: s_res = lt ? h_b : h_a;
			fpq8_pkg::OP_TO_INT: s_res = h_a[W-1] ? (~ti_m + W'(1)) : ti_m;
			fpq8_pkg::OP_FROM_INT: begin
				if (h_a[W-1]) begin
					if (h_ma > FI_NEG_LIM) begin
						s_res = WMIN;
						s_err = fpq8_pkg::ERR_OVF;
					end else begin
						s_res = ~(h_ma << F) + W'(1);
					end
				end else begin
					if (h_ma > FI_POS_LIM) begin
						s_res = WMAX;
						s_err = fpq8_pkg::ERR_OVF;
					end else begin
						s_res = h_ma << F;
					end
				end
			end
			default: ;
		endcase
	end

	// ---------------- multiplier: four half-width products ----------------
	logic [2*H-1:0] mpa;
	logic [2*H-1:0] mpb;
	logic [2*H-1:0] p00_s1, p01_s1, p10_s1, p11_s1;
	logic [2*H-1:0] p00_s2, p11_s2;
	logic [2*H:0]   mid_s2;
	logic [PW-1:0]  prod_s3;
	logic [PW:0]    prod_r;
	logic [MW-1:0]  mulm_s4;

	assign mpa    = (2*H)'(h_ma);
	assign mpb    = (2*H)'(h_mb);
	assign prod_r = {1'b0, prod_s3} + MUL_HALF;

	always_ff @(posedge clk) begin
		if (adv) begin
			p00_s1  <= mpa[H-1:0]   * mpb[H-1:0];
			p01_s1  <= mpa[H-1:0]   * mpb[2*H-1:H];
			p10_s1  <= mpa[2*H-1:H] * mpb[H-1:0];
			p11_s1  <= mpa[2*H-1:H] * mpb[2*H-1:H];
			p00_s2  <= p00_s1;
			p11_s2  <= p11_s1;
			mid_s2  <= {1'b0, p01_s1} + {1'b0, p10_s1};
			prod_s3 <= {p11_s2, p00_s2} + (PW'(mid_s2) << H);
			mulm_s4 <= MW'(prod_r >> F);
		end
	end

	// ---------------- divider chain, one quotient bit per stage ----------------
	logic           vld_s  [1:NQ];
	fpq8_pkg::ctl_t ctl_s  [1:NQ];
	logic [W-1:0]   sres_s [1:NQ];
	logic           scmp_s [1:NQ];
	fpq8_pkg::err_t serr_s [1:NQ];
	logic [W-1:0]   rem_s  [1:NQ];
	logic [W-1:0]   mbd_s  [1:NQ];
	logic [NQ-1:0]  num_s  [1:NQ];
	logic [NQ-1:0]  quo_s  [1:NQ];
	logic [MW-1:0]  mulm_s [5:NQ];

	genvar k;
	for (k = 1; k <= NQ; k++) begin : g_div
		logic           p_vld;
		fpq8_pkg::ctl_t p_ctl;
		logic [W-1:0]   p_sres;
		logic           p_scmp;
		fpq8_pkg::err_t p_serr;
		logic [W-1:0]   p_rem;
		logic [W-1:0]   p_mb;
		logic [NQ-1:0]  p_num;
		logic [NQ-1:0]  p_quo;
		logic [W:0]     trial;
		logic           ge;

		if (k == 1) begin : g_first
			assign p_vld  = pop;
			assign p_ctl  = h_ctl;
			assign p_sres = s_res;
			assign p_scmp = s_cmp;
			assign p_serr = s_err;
			assign p_rem  = '0;
			assign p_mb   = h_mb;
			assign p_num  = {h_ma, {F{1'b0}}};
			assign p_quo  = '0;
		end else begin : g_next
			assign p_vld  = vld_s[k-1];
			assign p_ctl  = ctl_s[k-1];
			assign p_sres = sres_s[k-1];
			assign p_scmp = scmp_s[k-1];
			assign p_serr = serr_s[k-1];
			assign p_rem  = rem_s[k-1];
			assign p_mb   = mbd_s[k-1];
			assign p_num  = num_s[k-1];
			assign p_quo  = quo_s[k-1];
		end

		// Restoring step: bring down the next numerator bit
		assign trial = {p_rem, p_num[NQ-1]};
		assign ge    = (trial >= {1'b0, p_mb});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (adv) begin
				vld_s[k] <= p_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				ctl_s[k]  <= p_ctl;
				sres_s[k] <= p_sres;
				scmp_s[k] <= p_scmp;
				serr_s[k] <= p_serr;
				rem_s[k]  <= ge ? W'(trial - {1'b0, p_mb}) : trial[W-1:0];
				mbd_s[k]  <= p_mb;
				num_s[k]  <= p_num << 1;
				quo_s[k]  <= {p_quo[NQ-2:0], ge};
			end
		end

		// Multiplier result rides along to the merge stage
		if (k >= 5) begin : g_mul_delay
			always_ff @(posedge clk) begin
				if (adv) begin
					mulm_s[k] <= (k == 5) ? mulm_s4 : mulm_s[(k > 5) ? k - 1 : 5];
				end
			end
		end
	end

	// ---------------- merge: round the quotient, pick the magnitude ----------------
	logic           div_rnd;
	logic           fin_vld_q;
	fpq8_pkg::ctl_t fin_ctl_q;
	logic [W-1:0]   fin_sres_q;
	logic           fin_scmp_q;
	fpq8_pkg::err_t fin_serr_q;
	logic [MW-1:0]  fin_mag_q;

	// Half away from zero: round up when twice the remainder reaches the divisor
	assign div_rnd = ({rem_s[NQ], 1'b0} >= {1'b0, mbd_s[NQ]});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_vld_q <= 1'b0;
		end else if (adv) begin
			fin_vld_q <= vld_s[NQ];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fin_ctl_q  <= ctl_s[NQ];
			fin_sres_q <= sres_s[NQ];
			fin_scmp_q <= scmp_s[NQ];
			fin_serr_q <= serr_s[NQ];
			fin_mag_q  <= (ctl_s[NQ].kind == fpq8_pkg::KIND_DIV)
			              ? (MW'(quo_s[NQ]) + MW'(div_rnd)) : mulm_s[NQ];
		end
	end

	// ---------------- saturate and register the response ----------------
	logic [MW-1:0]  lim;
	logic           mag_ovf;
	logic [W-1:0]   mag_w;
	logic [W-1:0]   out_res_q;
	logic           out_cmp_q;
	fpq8_pkg::err_t out_err_q;

	assign lim     = fin_ctl_q.neg ? MW'(WMIN) : MW'(WMAX);
	assign mag_ovf = (fin_mag_q > lim);
	assign mag_w   = fin_mag_q[W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= fin_vld_q;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (fin_ctl_q.kind == fpq8_pkg::KIND_SIMPLE) begin
				out_res_q <= fin_sres_q;
				out_cmp_q <= fin_scmp_q;
				out_err_q <= fin_serr_q;
			end else if (fin_ctl_q.kind == fpq8_pkg::KIND_DIV && fin_ctl_q.dz) begin
				out_res_q <= '0;
				out_cmp_q <= 1'b0;
				out_err_q <= fpq8_pkg::ERR_DIV0;
			end else if (mag_ovf) begin
				out_res_q <= fin_ctl_q.neg ? WMIN : WMAX;
				out_cmp_q <= 1'b0;
				out_err_q <= fpq8_pkg::ERR_OVF;
			end else begin
				out_res_q <= fin_ctl_q.neg ? (~mag_w + W'(1)) : mag_w;
				out_cmp_q <= 1'b0;
				out_err_q <= fpq8_pkg::ERR_OK;
			end
		end
	end

	assign rsp_valid    = out_vld_q;
	assign result_value = out_res_q;
	assign compare_true = out_cmp_q;
	assign error_code   = out_err_q;

`ifndef SYNTHESIS
	// Division by zero reports a zero result and no comparison
	a_div0_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && error_code == fpq8_pkg::ERR_DIV0 |-> result_value == '0 && !compare_true)
		else $error("div by zero response not cleared");

	// A true comparison always carries a zero value and no error
	a_cmp_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && compare_true |-> result_value == '0 && error_code == fpq8_pkg::ERR_OK)
		else $error("comparison response carries value or error");

	// Overflow always saturates to one of the two extremes
	a_ovf_sat: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && error_code == fpq8_pkg::ERR_OVF |-> result_value == WMIN || result_value == WMAX)
		else $error("overflow response not saturated");
`endif

endmodule

// ----- rtl/core/fixed_point_q8_alu_unit.sv -----
// Top level of the signed fixed-point ALU: front end, request queue, back end.
// Throughput: one request per cycle while no response is held; the divider takes one quotient bit per stage.
// A held response freezes the back end; the two-entry queue keeps accepting meanwhile until it is full.
// Reset (arst_n low, asynchronous) empties the queue and clears all stage valids.
module fixed_point_q8_alu_unit #(
	parameter int WORD_BITS = fpq8_pkg::WORD_BITS_DEF,
	parameter int FRAC_BITS = fpq8_pkg::FRAC_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_stall,
	input  logic [3:0]                  opcode,
	input  logic signed [WORD_BITS-1:0] operand_a,
	input  logic signed [WORD_BITS-1:0] operand_b,
	output logic                        rsp_valid,
	input  logic                        rsp_stall,
	output logic signed [WORD_BITS-1:0] result_value,
	output logic                        compare_true,
	output logic [1:0]                  error_code
);

	localparam int W     = WORD_BITS;
	localparam int ENT_W = $bits(fpq8_pkg::ctl_t) + 4 + 4 * W;

	fpq8_pkg::ctl_t f_ctl;
	logic [W-1:0]   f_ma;
	logic [W-1:0]   f_mb;
	logic           q_full;
	logic           q_empty;
	logic           q_pop;
	logic [ENT_W-1:0] q_head;
	fpq8_pkg::ctl_t h_ctl;
	logic [3:0]     h_op;
	logic [W-1:0]   h_a;
	logic [W-1:0]   h_b;
	logic [W-1:0]   h_ma;
	logic [W-1:0]   h_mb;
	logic [W-1:0]   res_w;

	assign req_stall = q_full;

	fpq8_front #(
		.WORD_BITS(WORD_BITS)
	) u_front (
		.opcode   (opcode),
		.operand_a(operand_a),
		.operand_b(operand_b),
		.ctl      (f_ctl),
		.mag_a    (f_ma),
		.mag_b    (f_mb)
	);

	fpq8_queue #(
		.DATA_W(ENT_W),
		.DEPTH (fpq8_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (req_valid && !q_full),
		.push_data({f_ctl, opcode, operand_a, operand_b, f_ma, f_mb}),
		.full     (q_full),
		.pop      (q_pop),
		.empty    (q_empty),
		.head     (q_head)
	);

	assign {h_ctl, h_op, h_a, h_b, h_ma, h_mb} = q_head;

	fpq8_back #(
		.WORD_BITS(WORD_BITS),
		.FRAC_BITS(FRAC_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (!q_empty),
		.pop         (q_pop),
		.h_ctl       (h_ctl),
		.h_op        (h_op),
		.h_a         (h_a),
		.h_b         (h_b),
		.h_ma        (h_ma),
		.h_mb        (h_mb),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.result_value(res_w),
		.compare_true(compare_true),
		.error_code  (error_code)
	);

	assign result_value = res_w;

endmodule

// ----- tb/tb_fixed_point_q8_alu_unit.sv -----
// Self-checking testbench for the Q24.8 fixed-point ALU with random handshake pressure.
module tb_fixed_point_q8_alu_unit;
	timeunit 1ns;
	timeprecision 1ps;
	import fpq8_pkg::*;

	localparam int FB = 8;
	localparam int LATENCY = 42;
	localparam int WATCHDOG = 20000;

	typedef struct {
		opcode_t            op;
		logic signed [31:0] a;
		logic signed [31:0] b;
	} alu_req_t;

	typedef struct {
		logic signed [31:0] value;
		logic               cmp;
		err_t               err;
	} alu_rsp_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	logic [3:0] opcode = '0;
	logic signed [31:0] operand_a = '0;
	logic signed [31:0] operand_b = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	logic signed [31:0] result_value;
	logic compare_true;
	logic [1:0] error_code;

	alu_req_t pending_reqs[$];
	alu_rsp_t expected_rsps[$];
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_cycles = 0;
	int mismatches = 0;
	int accepted_reqs = 0;
	int checked_rsps = 0;
	int quiet_cycles = 0;
	int op_seen[16];

	fixed_point_q8_alu_unit dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Saturate a wide signed value into a 32-bit word
	function automatic alu_rsp_t saturate(input logic signed [127:0] v);
		alu_rsp_t r;
		r.cmp = 1'b0;
		r.err = ERR_OK;
		r.value = v[31:0];
		if (v > 128'sd2147483647) begin
			r.value = 32'h7fffffff;
			r.err = ERR_OVF;
		end else if (v < -128'sd2147483648) begin
			r.value = 32'h80000000;
			r.err = ERR_OVF;
		end
		return r;
	endfunction

	// Round a nonnegative quotient n/d half away from zero
	function automatic logic [127:0] round_div(input logic [127:0] n, input logic [127:0] d);
		logic [127:0] q;
		logic [127:0] rem;
		q = n / d;
		rem = n % d;
		if (rem >= d - rem)
			q = q + 1;
		return q;
	endfunction

	// Expected result of one ALU operation
	function automatic alu_rsp_t alu_predict(input alu_req_t q);
		alu_rsp_t r;
		logic signed [127:0] a;
		logic signed [127:0] b;
		logic [127:0] ma;
		logic [127:0] mb;
		logic [127:0] m;
		logic neg;
		a = q.a;
		b = q.b;
		ma = (a < 0) ? -a : a;
		mb = (b < 0) ? -b : b;
		neg = (a < 0) != (b < 0);
		r.value = '0;
		r.cmp = 1'b0;
		r.err = ERR_OK;
		case (q.op)
			OP_ADD: r = saturate(a + b);
			OP_SUB: r = saturate(a - b);
			OP_MUL: begin
				m = round_div(ma * mb, 128'd1 << FB);
				r = saturate(neg ? -$signed(m) : $signed(m));
			end
			OP_DIV: begin
				if (mb == 0) begin
					r.err = ERR_DIV0;
				end else begin
					m = round_div(ma << FB, mb);
					r = saturate(neg ? -$signed(m) : $signed(m));
				end
			end
			OP_GT: r.cmp = a > b;
			OP_LT: r.cmp = a < b;
			OP_GE: r.cmp = a >= b;
			OP_LE: r.cmp = a <= b;
			OP_EQ: r.cmp = a == b;
			OP_NE: r.cmp = a != b;
			OP_MIN: r.value = (a < b) ? q.a : q.b;
			OP_MAX: r.value = (a < b) ? q.b : q.a;
			OP_INC: r = saturate(a + 1);
			OP_DEC: r = saturate(a - 1);
			OP_TO_INT: begin
				m = (ma + (128'd1 << (FB - 1))) >> FB;
				r.value = (a < 0) ? -$signed(m) : $signed(m);
			end
			default: r = saturate(a * (128'sd1 <<< FB));
		endcase
		return r;
	endfunction

	function automatic logic [31:0] pick_operand();
		case ($urandom_range(0, 9))
			0: return 32'h7fffffff - $urandom_range(0, 3);
			1: return 32'h80000000 + $urandom_range(0, 3);
			2: return $urandom_range(0, 600) - 300;
			3: return $urandom_range(0, 1) ? 32'h0080 : 32'hffffff80;
			4: return $signed($urandom()) >>> $urandom_range(8, 24);
			default: return $urandom();
		endcase
	endfunction

	task automatic push_req(input opcode_t op, input logic [31:0] a, input logic [31:0] b);
		alu_req_t q;
		q.op = op;
		q.a = a;
		q.b = b;
		pending_reqs.push_back(q);
	endtask

	// Request driver: offers the queue head, holds payload while stalled
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && !req_stall) begin
				alu_req_t q;
				q.op = opcode_t'(opcode);
				q.a = operand_a;
				q.b = operand_b;
				expected_rsps.push_back(alu_predict(q));
				op_seen[opcode]++;
				accepted_reqs++;
			end
			if (!req_valid || !req_stall) begin
				if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					alu_req_t q;
					q = pending_reqs.pop_front();
					req_valid <= 1'b1;
					opcode <= q.op;
					operand_a <= q.a;
					operand_b <= q.b;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// Response monitor and stall generator
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				if (expected_rsps.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected response value=%0d", result_value);
				end else begin
					alu_rsp_t e;
					e = expected_rsps.pop_front();
					checked_rsps++;
					if (e.value !== result_value || e.cmp !== compare_true
							|| e.err !== error_code) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: exp %0d/%0b/%0d got %0d/%0b/%0d",
								e.value, e.cmp, e.err, result_value, compare_true,
								error_code);
					end
				end
			end
			if (hold_cycles > 0) begin
				hold_cycles <= hold_cycles - 1;
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
			end
		end
	end

	// Watchdog on cycles without any handshake
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG) begin
			$display("tb_fixed_point_q8_alu_unit failed");
			$finish;
		end
	end

	task automatic drain();
		while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0)
			@(posedge clk);
	endtask

	task automatic random_phase(input int n);
		for (int i = 0; i < n; i++)
			push_req(opcode_t'($urandom_range(0, 15)), pick_operand(), pick_operand());
	endtask

	initial begin
		int ops_hit;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Directed corners: every opcode, extremes, rounding halves, zero divisor
		push_req(OP_ADD, 32'h7fffffff, 32'h1);
		push_req(OP_SUB, 32'h80000000, 32'h1);
		push_req(OP_MUL, 32'h7fffffff, 32'h7fffffff);
		push_req(OP_MUL, 32'h00000001, 32'h00000080);
		push_req(OP_MUL, 32'hffffffff, 32'h00000080);
		push_req(OP_MUL, 32'h80000000, 32'h00000100);
		push_req(OP_DIV, 32'h00000100, 32'h0);
		push_req(OP_DIV, 32'h80000000, 32'hffffff00);
		push_req(OP_DIV, 32'h00000001, 32'h00000200);
		push_req(OP_DIV, 32'h80000000, 32'h00000001);
		push_req(OP_GT, 32'h80000000, 32'h7fffffff);
		push_req(OP_LT, 32'h80000000, 32'h7fffffff);
		push_req(OP_GE, 32'h5, 32'h5);
		push_req(OP_LE, 32'h7fffffff, 32'h80000000);
		push_req(OP_EQ, 32'hffffffff, 32'hffffffff);
		push_req(OP_NE, 32'h0, 32'hffffffff);
		push_req(OP_MIN, 32'h80000000, 32'h7fffffff);
		push_req(OP_MAX, 32'h80000000, 32'h7fffffff);
		push_req(OP_INC, 32'h7fffffff, 32'h0);
		push_req(OP_DEC, 32'h80000000, 32'hffffffff);
		push_req(OP_TO_INT, 32'h80000000, 32'h0);
		push_req(OP_TO_INT, 32'hffffff80, 32'h0);
		push_req(OP_FROM_INT, 32'h00800000, 32'h0);
		push_req(OP_FROM_INT, 32'hff800000, 32'h0);
		push_req(OP_FROM_INT, 32'hff7fffff, 32'h0);
		drain();

		// Long receiver hold while the sender keeps offering
		random_phase(60);
		hold_cycles = 150;
		drain();

		send_idle_pct = 14;
		recv_idle_pct = 48;
		random_phase(550);
		drain();
		send_idle_pct = 48;
		recv_idle_pct = 14;
		random_phase(500);
		drain();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_phase(500);
		drain();
		repeat (LATENCY + 10) @(posedge clk);

		ops_hit = 0;
		foreach (op_seen[i])
			if (op_seen[i] > 0)
				ops_hit++;
		$display("Ran %0d requests across %0d opcodes, %0d responses checked, %0d mismatches.",
			accepted_reqs, ops_hit, checked_rsps, mismatches);
		if (mismatches == 0 && expected_rsps.size() == 0)
			$display("tb_fixed_point_q8_alu_unit passed");
		else
			$display("tb_fixed_point_q8_alu_unit failed");
		$finish;
	end
endmodule
